[rtl/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

   localparam int OP_W       = 1;
   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int IDX_W      = 11;
   localparam int OFF_W      = 11;
   localparam int ROW_OUT_W  = 5;
   localparam int COL_OUT_W  = 7;
   localparam int DATA_W     = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [OP_W-1:0]   OP_PUT  = 1'b0;
   localparam logic [OP_W-1:0]   OP_READ = 1'b1;

   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LINEFEED  = 8'h0A;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   localparam logic CSR_ATTR_WORD = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_WIPE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

[rtl/tcw_ifs.sv]
`default_nettype none

interface tcw_req_if
   import tcw_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [CHAR_W-1:0] char_code;
   logic [IDX_W-1:0]  read_index;

   modport source (output valid, output operation, output char_code, output read_index,
                   input ready);
   modport sink   (input valid, input operation, input char_code, input read_index,
                   output ready);
endinterface

interface tcw_rsp_if
   import tcw_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [OFF_W-1:0]     cursor_offset;
   logic [ROW_OUT_W-1:0] cursor_row;
   logic [COL_OUT_W-1:0] cursor_col;
   logic                 scrolled;
   logic [CHAR_W-1:0]    cell_char;
   logic [ATTR_W-1:0]    cell_attr;

   modport source (output valid, output cursor_offset, output cursor_row, output cursor_col,
                   output scrolled, output cell_char, output cell_attr, input ready);
   modport sink   (input valid, input cursor_offset, input cursor_row, input cursor_col,
                   input scrolled, input cell_char, input cell_attr, output ready);
endinterface

`default_nettype wire

[rtl/text_console_writer.sv]
`default_nettype none

// Channel   Dir  Handshake      Payload
// req_chan  in   valid/ready    operation, char_code, read_index
// rsp_chan  out  valid/ready    cursor_offset, cursor_row, cursor_col, scrolled,
//                               cell_char, cell_attr
// csr_*     in   APB write      text_attribute at word 0
//
// A put or read steps through accept, one memory access and result load.
// A put that scrolls adds a row copy through the single memory port pair
// and then a clear of the bottom text row. After reset a clearing pass
// zeroes the whole cell memory; req_chan.ready stays low meanwhile. A new
// item is taken while the previous result waits in the output register;
// a stalled result holds the next one.

module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   tcw_req_if.sink               req_chan,
   tcw_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0]     csr_pwdata,
   output logic [DATA_W-1:0]     csr_prdata,
   output logic                  csr_pready
);

   localparam int CELLS      = ROWS * COLUMNS;
   localparam int MOVE_CELLS = (ROWS - 2) * COLUMNS;
   localparam int WIPE_LAST  = (ROWS - 1) * COLUMNS - 1;
   localparam int AW         = $clog2(CELLS);
   localparam int CW         = $clog2(CELLS + 1);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int COL_W      = $clog2(COLUMNS + 1);

   state_type state_ff, state_in;

   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ATTR_W-1:0] attr_ff;
   logic              scrolled_ff, scrolled_in;
   logic              in_range_ff;

   logic [OP_W-1:0]   op_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [IDX_W-1:0]  ridx_ff;

   logic [CHAR_W-1:0] char_mem_ff [CELLS];
   logic [ATTR_W-1:0] attr_mem_ff [CELLS];
   logic [CHAR_W-1:0] rd_char_ff;
   logic [ATTR_W-1:0] rd_attr_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [OFF_W-1:0]     off_ff;
   logic [ROW_OUT_W-1:0] row_out_ff;
   logic [COL_OUT_W-1:0] col_out_ff;
   logic                 scr_out_ff;
   logic [CHAR_W-1:0]    cchar_ff;
   logic [ATTR_W-1:0]    cattr_ff;

   logic              we_char, we_attr, re;
   logic [AW-1:0]     waddr, raddr;
   logic [CHAR_W-1:0] wchar;
   logic [ATTR_W-1:0] wattr;
   logic              req_ready;
   logic              rsp_load;
   logic              csr_write;

   logic [CW-1:0]     cur_pos;
   logic [CW-1:0]     put_addr;
   logic              put_we_char, put_we_attr;
   logic [CHAR_W-1:0] put_char;
   logic [ROW_W-1:0]  row_step, row_wrap, row_fin;
   logic [COL_W-1:0]  col_step, col_fin;
   logic              put_scroll;

   assign cur_pos = CW'(row_ff) * CW'(COLUMNS) + CW'(col_ff);

   always_comb begin
      row_step    = row_ff;
      col_step    = col_ff;
      put_we_char = 1'b0;
      put_we_attr = 1'b0;
      put_addr    = cur_pos;
      put_char    = char_ff;
      priority if (char_ff == CH_BACKSPACE) begin
         if (col_ff != '0) begin
            col_step    = col_ff - 1'b1;
            put_we_char = 1'b1;
            put_addr    = cur_pos - 1'b1;
            put_char    = '0;
         end
      end else if (char_ff == CH_RETURN) begin
         col_step = '0;
      end else if (char_ff == CH_LINEFEED) begin
         col_step = '0;
         row_step = row_ff + 1'b1;
      end else begin
         put_we_char = 1'b1;
         put_we_attr = 1'b1;
         col_step    = col_ff + 1'b1;
      end
      if (32'(col_step) >= COLUMNS) begin
         col_fin  = '0;
         row_wrap = row_step + 1'b1;
      end else begin
         col_fin  = col_step;
         row_wrap = row_step;
      end
      put_scroll = (32'(row_wrap) >= ROWS - 1);
      row_fin    = put_scroll ? row_wrap - 1'b1 : row_wrap;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == CW'(CELLS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_chan.valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (op_ff == OP_READ) state_in = ST_DONE;
            else if (put_scroll) state_in = ST_SCROLL;
            else state_in = ST_DONE;
         end
         ST_SCROLL: begin
            if (cnt_ff == CW'(MOVE_CELLS)) state_in = ST_WIPE;
         end
         ST_WIPE: begin
            if (cnt_ff == CW'(WIPE_LAST)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      we_char   = 1'b0;
      we_attr   = 1'b0;
      waddr     = AW'(cnt_ff);
      wchar     = '0;
      wattr     = '0;
      re        = 1'b0;
      raddr     = AW'(cnt_ff + CW'(COLUMNS));
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR, ST_WIPE: begin
            we_char = 1'b1;
            we_attr = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_EXEC: begin
            if (op_ff == OP_READ) begin
               re    = 1'b1;
               raddr = AW'(ridx_ff);
            end else begin
               we_char = put_we_char;
               we_attr = put_we_attr;
               waddr   = AW'(put_addr);
               wchar   = put_char;
               wattr   = attr_ff;
            end
         end
         ST_SCROLL: begin
            re = (cnt_ff != CW'(MOVE_CELLS));
            if (cnt_ff != '0) begin
               we_char = 1'b1;
               we_attr = 1'b1;
               waddr   = AW'(cnt_ff - 1'b1);
               wchar   = rd_char_ff;
               wattr   = rd_attr_ff;
            end
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_chan.ready;
         end
         default: ;
      endcase
   end

   always_comb begin
      cnt_in      = cnt_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      scrolled_in = scrolled_ff;
      unique case (state_ff)
         ST_CLEAR, ST_WIPE: cnt_in = cnt_ff + 1'b1;
         ST_EXEC: begin
            cnt_in = '0;
            if (op_ff == OP_READ) begin
               scrolled_in = 1'b0;
            end else begin
               row_in      = row_fin;
               col_in      = col_fin;
               scrolled_in = put_scroll;
            end
         end
         ST_SCROLL: begin
            if (cnt_ff != CW'(MOVE_CELLS)) cnt_in = cnt_ff + 1'b1;
         end
         default: ;
      endcase
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite
                      && (csr_paddr[CSR_ADDR_W-1] == CSR_ATTR_WORD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         scrolled_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         attr_ff      <= ATTR_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         scrolled_ff  <= scrolled_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) attr_ff <= csr_pwdata[ATTR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_chan.valid) begin
         op_ff       <= req_chan.operation;
         char_ff     <= req_chan.char_code;
         ridx_ff     <= req_chan.read_index;
         in_range_ff <= (32'(req_chan.read_index) < CELLS);
      end
      if (rsp_load) begin
         off_ff     <= OFF_W'(cur_pos);
         row_out_ff <= ROW_OUT_W'(row_ff);
         col_out_ff <= COL_OUT_W'(col_ff);
         scr_out_ff <= scrolled_ff;
         cchar_ff   <= (op_ff == OP_READ && in_range_ff) ? rd_char_ff : '0;
         cattr_ff   <= (op_ff == OP_READ && in_range_ff) ? rd_attr_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (we_char) char_mem_ff[waddr] <= wchar;
      if (we_attr) attr_mem_ff[waddr] <= wattr;
      if (re) begin
         rd_char_ff <= char_mem_ff[raddr];
         rd_attr_ff <= attr_mem_ff[raddr];
      end
   end

   assign req_chan.ready         = req_ready;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.cursor_offset = off_ff;
   assign rsp_chan.cursor_row    = row_out_ff;
   assign rsp_chan.cursor_col    = col_out_ff;
   assign rsp_chan.scrolled      = scr_out_ff;
   assign rsp_chan.cell_char     = cchar_ff;
   assign rsp_chan.cell_attr     = cattr_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_ATTR_WORD)
                       ? DATA_W'(attr_ff) : '0;

endmodule

`default_nettype wire

[rtl/tcw_checker.sv]
`default_nettype none

module tcw_checker
   import tcw_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   tcw_req_if.sink              req_chan,
   tcw_rsp_if.source            rsp_chan,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [DATA_W-1:0]     csr_pwdata,
   input logic [DATA_W-1:0]     csr_prdata,
   input logic                  csr_pready
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && !req_chan.ready)
      else $error("result or ready seen right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid
         && $stable(rsp_chan.cursor_offset) && $stable(rsp_chan.cursor_row)
         && $stable(rsp_chan.cursor_col) && $stable(rsp_chan.scrolled)
         && $stable(rsp_chan.cell_char) && $stable(rsp_chan.cell_attr))
      else $error("stalled item changed");

   a_cell_no_scroll: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.cell_char != '0 || rsp_chan.cell_attr != '0)
         |-> !rsp_chan.scrolled)
      else $error("read item reports a scroll");

   a_scroll_col0: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.scrolled |-> rsp_chan.cursor_col == '0)
      else $error("scroll left cursor off column zero");

   a_attr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready
         && csr_paddr[CSR_ADDR_W-1] == CSR_ATTR_WORD
         |=> csr_paddr[CSR_ADDR_W-1] != CSR_ATTR_WORD
             || csr_prdata[ATTR_W-1:0] == $past(csr_pwdata[ATTR_W-1:0]))
      else $error("attribute readback mismatch");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_chan    (req_chan),
   .rsp_chan    (rsp_chan),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata),
   .csr_pready  (csr_pready)
);

`default_nettype wire

[tb/text_console_writer_checker.sv]
`timescale 1ns / 1ps

module text_console_writer_checker
   import tcw_pkg::*;
#(
   parameter int                    COLUMNS   = 80,
   parameter int                    ROWS      = 25,
   parameter logic [CSR_ADDR_W-1:0] ATTR_ADDR = '0
) (
   input  logic                  clock,
   input  logic                  reset,
   tcw_req_if                    req_chan,
   tcw_rsp_if                    rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0]     csr_pwdata,
   output int                    mismatches,
   output int                    outstanding
);

   localparam int CELLS = COLUMNS * ROWS;

   typedef struct packed {
      logic [OFF_W-1:0]     cursor_offset;
      logic [ROW_OUT_W-1:0] cursor_row;
      logic [COL_OUT_W-1:0] cursor_col;
      logic                 scrolled;
      logic [CHAR_W-1:0]    cell_char;
      logic [ATTR_W-1:0]    cell_attr;
   } console_view_type;

   logic [ATTR_W+CHAR_W-1:0] screen [CELLS];
   int unsigned              row_now;
   int unsigned              col_now;
   logic [ATTR_W-1:0]        attribute;
   console_view_type         awaited_views [$];

   function automatic console_view_type advance_console(input logic [OP_W-1:0]   op,
                                                        input logic [CHAR_W-1:0] ch,
                                                        input logic [IDX_W-1:0]  idx);
      console_view_type view;
      int unsigned      pos;
      view = '0;
      if (op == OP_READ) begin
         if (idx < CELLS) {view.cell_attr, view.cell_char} = screen[idx];
      end else begin
         if (ch == CH_BACKSPACE) begin
            if (col_now > 0) begin
               col_now--;
               pos = row_now * COLUMNS + col_now;
               if (pos < CELLS) screen[pos][CHAR_W-1:0] = '0;
            end
         end else if (ch == CH_RETURN) begin
            col_now = 0;
         end else if (ch == CH_LINEFEED) begin
            col_now = 0;
            row_now++;
         end else begin
            pos = row_now * COLUMNS + col_now;
            if (pos < CELLS) screen[pos] = {attribute, ch};
            col_now++;
         end
         if (col_now >= COLUMNS) begin
            col_now = 0;
            row_now++;
         end
         if (row_now >= ROWS - 1) begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (int i = (ROWS - 2) * COLUMNS; i < (ROWS - 1) * COLUMNS; i++) screen[i] = '0;
            row_now--;
            view.scrolled = 1'b1;
         end
      end
      view.cursor_offset = OFF_W'(row_now * COLUMNS + col_now);
      view.cursor_row    = ROW_OUT_W'(row_now);
      view.cursor_col    = COL_OUT_W'(col_now);
      return view;
   endfunction

   task automatic compare_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      console_view_type seen;
      console_view_type due;
      if (reset) begin
         foreach (screen[i]) screen[i] = '0;
         row_now    = 0;
         col_now    = 0;
         attribute  = ATTR_RESET;
         mismatches = 0;
         awaited_views.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == ATTR_ADDR)
            attribute = csr_pwdata[ATTR_W-1:0];
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen = {rsp_chan.cursor_offset, rsp_chan.cursor_row, rsp_chan.cursor_col,
                    rsp_chan.scrolled, rsp_chan.cell_char, rsp_chan.cell_attr};
            if (awaited_views.size() == 0) begin
               $display("%0t: result expected none, actual offset %0d char %0d attr %0d",
                        $time, seen.cursor_offset, seen.cell_char, seen.cell_attr);
               mismatches++;
            end else begin
               due = awaited_views.pop_front();
               compare_field("cursor_offset", due.cursor_offset, seen.cursor_offset);
               compare_field("cursor_row", due.cursor_row, seen.cursor_row);
               compare_field("cursor_col", due.cursor_col, seen.cursor_col);
               compare_field("scrolled", due.scrolled, seen.scrolled);
               compare_field("cell_char", due.cell_char, seen.cell_char);
               compare_field("cell_attr", due.cell_attr, seen.cell_attr);
            end
         end
         if (req_chan.valid && req_chan.ready)
            awaited_views.push_back(advance_console(req_chan.operation, req_chan.char_code,
                                                    req_chan.read_index));
      end
      outstanding = awaited_views.size();
   end

endmodule

[tb/text_console_writer_tb.sv]
`timescale 1ns / 1ps

module text_console_writer_tb;
   import tcw_pkg::*;

   localparam int                    COLUMNS      = 80;
   localparam int                    ROWS         = 25;
   localparam int                    CELLS        = COLUMNS * ROWS;
   localparam int                    PHASES       = 5;
   localparam int                    RANDOM_ITEMS = 1330;
   localparam int                    CYCLE_LIMIT  = 15_000_000;
   localparam logic [CSR_ADDR_W-1:0] ATTR_ADDR    = {CSR_ATTR_WORD, 2'b00};

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0]     csr_pwdata;
   logic [DATA_W-1:0]     csr_prdata;
   logic                  csr_pready;
   int                    mismatches;
   int                    outstanding;
   int                    cycles = 0;
   int                    burst_left;
   int                    items_sent;

   tcw_req_if req_chan ();
   tcw_rsp_if rsp_chan ();

   text_console_writer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   text_console_writer_checker #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .ATTR_ADDR (ATTR_ADDR)
   ) console_shadow (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("text_console_writer_tb NOT OK");
         $finish;
      end
   end

   initial begin
      int mode;
      int span;
      rsp_chan.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = (mode == 3) ? $urandom_range(1, 30) : $urandom_range(16, 96);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0: rsp_chan.ready = 1'b1;
               1: rsp_chan.ready = ($urandom_range(0, 3) != 0);
               2: rsp_chan.ready = ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready = 1'b0;
            endcase
         end
      end
   end

   task automatic send_request(input logic [OP_W-1:0]   op,
                               input logic [CHAR_W-1:0] ch,
                               input logic [IDX_W-1:0]  idx);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(0, 2);
         if (gap > 0) begin
            req_chan.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_chan.valid      = 1'b1;
      req_chan.operation  = op;
      req_chan.char_code  = ch;
      req_chan.read_index = idx;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      burst_left--;
      items_sent++;
   endtask

   // hold off until every result is back
   task automatic drain_results();
      req_chan.valid = 1'b0;
      burst_left     = 0;
      while (outstanding != 0) @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = ATTR_ADDR;
      csr_pwdata  = DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   function automatic logic [IDX_W-1:0] pick_cell_index();
      case ($urandom_range(0, 9))
         0, 1: return IDX_W'($urandom_range(0, 2 ** IDX_W - 1));
         2: return IDX_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
         default: return IDX_W'($urandom_range(0, CELLS - 2 * COLUMNS - 1));
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] pick_glyph();
      if ($urandom_range(0, 7) == 0) return CHAR_W'($urandom_range(0, 255));
      return CHAR_W'($urandom_range(32, 126));
   endfunction

   task automatic type_text(input int count);
      int target;
      int kind;
      int len;
      target = items_sent + count;
      while (items_sent < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 20);
            repeat (len) begin
               case ($urandom_range(0, 19))
                  0: send_request(OP_PUT, CH_BACKSPACE, IDX_W'($urandom));
                  1, 2: send_request(OP_READ, CHAR_W'($urandom), pick_cell_index());
                  default: send_request(OP_PUT, pick_glyph(), IDX_W'($urandom));
               endcase
            end
            case ($urandom_range(0, 3))
               0: send_request(OP_PUT, CH_RETURN, IDX_W'($urandom));
               1: begin
                  send_request(OP_PUT, CH_RETURN, IDX_W'($urandom));
                  send_request(OP_PUT, CH_LINEFEED, IDX_W'($urandom));
               end
               default: send_request(OP_PUT, CH_LINEFEED, IDX_W'($urandom));
            endcase
         end else if (kind < 85) begin
            repeat ($urandom_range(1, 8))
               send_request(OP_READ, CHAR_W'($urandom), pick_cell_index());
         end else if (kind < 95) begin
            repeat ($urandom_range(1, 5))
               send_request(OP_PUT, CH_BACKSPACE, IDX_W'($urandom));
         end else begin
            send_request(OP_W'($urandom), CHAR_W'($urandom), IDX_W'($urandom));
         end
      end
   endtask

   initial begin
      logic [ATTR_W-1:0] attr_plan [PHASES];
      attr_plan[0] = 8'hFF;
      attr_plan[1] = 8'h00;
      attr_plan[2] = ATTR_W'($urandom);
      attr_plan[3] = ATTR_W'($urandom);
      attr_plan[4] = 8'h80;
      burst_left          = 0;
      items_sent          = 0;
      req_chan.valid      = 1'b0;
      req_chan.operation  = OP_PUT;
      req_chan.char_code  = '0;
      req_chan.read_index = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      reset               = 1'b1;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      send_request(OP_READ, 8'h00, 11'd0);
      send_request(OP_READ, CH_LINEFEED, 11'(CELLS - 1));
      send_request(OP_READ, 8'hFF, 11'h7FF);
      send_request(OP_READ, CH_BACKSPACE, 11'(CELLS));
      send_request(OP_PUT, CH_BACKSPACE, 11'h7FF);
      send_request(OP_PUT, 8'h00, 11'd0);
      send_request(OP_PUT, 8'hFF, 11'h7FF);
      send_request(OP_PUT, 8'h41, 11'd0);
      send_request(OP_READ, 8'h00, 11'd0);
      send_request(OP_READ, 8'h00, 11'd1);
      send_request(OP_PUT, CH_BACKSPACE, 11'd0);
      send_request(OP_READ, 8'h00, 11'd2);
      send_request(OP_PUT, CH_RETURN, 11'd0);
      send_request(OP_READ, 8'h00, 11'd0);
      send_request(OP_PUT, CH_LINEFEED, 11'd0);
      send_request(OP_PUT, 8'h7F, 11'd0);
      send_request(OP_PUT, 8'h80, 11'd0);
      send_request(OP_READ, 8'h00, 11'(COLUMNS));
      send_request(OP_READ, 8'h00, 11'(COLUMNS + 1));
      send_request(OP_PUT, CH_BACKSPACE, 11'd0);
      send_request(OP_PUT, CH_BACKSPACE, 11'd0);
      send_request(OP_PUT, CH_BACKSPACE, 11'd0);
      send_request(OP_READ, 8'h00, 11'(COLUMNS));

      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         write_attribute(attr_plan[p]);
         type_text(RANDOM_ITEMS / PHASES);
      end

      drain_results();
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("text_console_writer_tb OK");
      end else begin
         $display("text_console_writer_tb NOT OK");
      end
      $finish;
   end

endmodule
